FILE: sv/l2lh_pkg.sv
// ----------------------------------------------------------------------------
// l2lh_pkg: shared constants for the log2 latency histogram
// Field widths, opcodes and bucket bound constants.
// ----------------------------------------------------------------------------
`default_nettype none

package l2lh_pkg;

    localparam int OPCODE_W = 2;
    localparam int LAT_W    = 64;
    localparam int PCT_W    = 17;
    localparam int SEL_W    = 6;
    localparam int VALUE_W  = 32;
    localparam int USED_W   = 5;
    localparam int TOTAL_W  = 37;

    localparam int Q16_BITS         = 16;
    localparam int SMALL_SHIFT      = 10;  // 1024 ns
    localparam int INDEX_OFFSET     = 9;
    localparam int BOUND_SHIFT_BASE = 10;
    localparam int TOP_SHIFT        = 30;

    typedef logic [OPCODE_W-1:0] t_opcode;

    localparam t_opcode OP_RECORD = 2'd0;
    localparam t_opcode OP_QUERY  = 2'd1;
    localparam t_opcode OP_READ   = 2'd2;
    localparam t_opcode OP_CLEAR  = 2'd3;

endpackage

`default_nettype wire

FILE: sv/l2lh_req_if.sv
// ----------------------------------------------------------------------------
// l2lh_req_if: request channel of the latency histogram
// Valid/ready handshake with opcode, latency sample, fraction and bucket select.
// ----------------------------------------------------------------------------
`default_nettype none

interface l2lh_req_if;

    logic                           valid;
    logic                           ready;
    l2lh_pkg::t_opcode              opcode;
    logic [l2lh_pkg::LAT_W-1:0]     latency;
    logic [l2lh_pkg::PCT_W-1:0]     pct_frac;
    logic [l2lh_pkg::SEL_W-1:0]     bucket_sel;

    modport source (output valid, output opcode, output latency, output pct_frac,
                    output bucket_sel, input ready);
    modport sink   (input valid, input opcode, input latency, input pct_frac,
                    input bucket_sel, output ready);

endinterface

`default_nettype wire

FILE: sv/l2lh_rsp_if.sv
// ----------------------------------------------------------------------------
// l2lh_rsp_if: response channel of the latency histogram
// Valid/ready handshake with value, bucket used and total count.
// ----------------------------------------------------------------------------
`default_nettype none

interface l2lh_rsp_if;

    logic                           valid;
    logic                           ready;
    logic [l2lh_pkg::VALUE_W-1:0]   value;
    logic [l2lh_pkg::USED_W-1:0]    bucket_used;
    logic [l2lh_pkg::TOTAL_W-1:0]   total_count;

    modport source (output valid, output value, output bucket_used,
                    output total_count, input ready);
    modport sink   (input valid, input value, input bucket_used,
                    input total_count, output ready);

endinterface

`default_nettype wire

FILE: sv/log2_latency_histogram.sv
// ----------------------------------------------------------------------------
// log2_latency_histogram: power-of-two bucket latency histogram
// A query runs a 16-step shift-add rank multiply (skipped for a fraction of
// one or more), then walks the buckets, reading each and adding it to the
// running sum until it passes the rank or reaches bucket BUCKETS-1.
// One request at a time; a new request is taken while a result waits.
// Synchronous active-low reset empties the histogram at once via valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module log2_latency_histogram #(
    parameter int BUCKETS     = 21,
    parameter int COUNT_WIDTH = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    l2lh_req_if.sink    i_req,
    l2lh_rsp_if.source  o_rsp
);

    localparam int IW = $clog2(BUCKETS);
    localparam int TW = (COUNT_WIDTH + IW > 64) ? 64 : COUNT_WIDTH + IW;
    localparam int PW = TW + l2lh_pkg::Q16_BITS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_REC   = 3'd2;
    localparam logic [2:0] S_RDB   = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_WREAD = 3'd5;
    localparam logic [2:0] S_WALK  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]                 r_state;
    l2lh_pkg::t_opcode          r_op;
    logic [IW-1:0]              r_addr;
    logic                       r_oor;
    logic [BUCKETS-1:0]         r_valid;
    logic [COUNT_WIDTH-1:0]     r_mem [BUCKETS];
    logic [COUNT_WIDTH-1:0]     r_rdata;
    logic                       r_rvld;
    logic [TW-1:0]              r_total;
    logic [PW-1:0]              r_acc;
    logic [TW-1:0]              r_cum;
    logic [TW-1:0]              r_target;
    logic [15:0]                r_pct;
    logic [3:0]                 r_mbit;
    logic [63:0]                r_res_value;
    logic [IW-1:0]              r_res_used;

    logic                       r_ov;
    logic [l2lh_pkg::VALUE_W-1:0] r_o_value;
    logic [l2lh_pkg::USED_W-1:0]  r_o_used;
    logic [l2lh_pkg::TOTAL_W-1:0] r_o_total;

    logic [IW-1:0]              w_bkt;
    logic [COUNT_WIDTH-1:0]     w_cnt;
    logic                       w_sat;
    logic                       w_we;
    logic [PW-1:0]              w_add_a;
    logic [PW-1:0]              w_add_b;
    logic [PW-1:0]              w_sum;
    logic [6:0]                 w_shamt;
    logic [63:0]                w_bound;
    logic [63:0]                w_cnt64;
    logic [63:0]                w_tot64;
    logic [7:0]                 w_used8;
    logic                       w_load;

    // bucket of the incoming sample: highest set bit wins
    always_comb begin
        w_bkt = '0;
        for (int k = l2lh_pkg::SMALL_SHIFT; k < l2lh_pkg::LAT_W; k++) begin
            if (i_req.latency[k]) begin
                w_bkt = (k - l2lh_pkg::INDEX_OFFSET < BUCKETS - 1)
                      ? IW'(k - l2lh_pkg::INDEX_OFFSET) : IW'(BUCKETS - 1);
            end
        end
    end

    assign w_cnt = r_rvld ? r_rdata : '0;
    assign w_sat = (w_cnt == {COUNT_WIDTH{1'b1}});
    assign w_we  = (r_state == S_REC) && !w_sat;

    // shared adder: rank multiply and cumulative walk
    always_comb begin
        if (r_state == S_MUL) begin
            w_add_a = r_acc << 1;
            w_add_b = r_pct[r_mbit] ? PW'(r_total) : '0;
        end else begin
            w_add_a = PW'(r_cum);
            w_add_b = PW'(w_cnt);
        end
    end
    assign w_sum = w_add_a + w_add_b;

    assign w_shamt = 7'(r_addr) + 7'(l2lh_pkg::BOUND_SHIFT_BASE);
    assign w_bound = (r_addr == IW'(BUCKETS - 1)) ? (64'd1 << l2lh_pkg::TOP_SHIFT)
                                                  : (64'd1 << w_shamt);
    assign w_cnt64 = 64'(w_cnt);
    assign w_tot64 = 64'(r_total);
    assign w_used8 = 8'(r_res_used);
    assign w_load  = (r_state == S_DONE) && (!r_ov || o_rsp.ready);

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_ov;
    assign o_rsp.value       = r_o_value;
    assign o_rsp.bucket_used = r_o_used;
    assign o_rsp.total_count = r_o_total;

    // bucket store
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_addr] <= w_cnt + 1'b1;
        end
        r_rdata <= r_mem[r_addr];
        r_rvld  <= r_valid[r_addr];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_total <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_op        <= i_req.opcode;
                        r_res_value <= '0;
                        r_res_used  <= '0;
                        r_oor       <= 1'b0;
                        unique case (i_req.opcode)
                            l2lh_pkg::OP_RECORD: begin
                                r_addr     <= w_bkt;
                                r_res_used <= w_bkt;
                                r_state    <= S_READ;
                            end
                            l2lh_pkg::OP_QUERY: begin
                                r_cum  <= '0;
                                r_addr <= '0;
                                r_acc  <= '0;
                                r_mbit <= 4'd15;
                                r_pct  <= i_req.pct_frac[15:0];
                                if (r_total == '0) begin
                                    r_state <= S_DONE;
                                end else if (i_req.pct_frac[16]) begin
                                    r_target <= r_total - 1'b1;
                                    r_state  <= S_WREAD;
                                end else begin
                                    r_state <= S_MUL;
                                end
                            end
                            l2lh_pkg::OP_READ: begin
                                if (7'(i_req.bucket_sel) >= 7'(BUCKETS)) begin
                                    r_oor  <= 1'b1;
                                    r_addr <= '0;
                                end else begin
                                    r_addr <= IW'(i_req.bucket_sel);
                                end
                                r_state <= S_READ;
                            end
                            default: begin
                                r_valid <= '0;
                                r_total <= '0;
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_state <= (r_op == l2lh_pkg::OP_RECORD) ? S_REC : S_RDB;
                end
                S_REC: begin
                    if (!w_sat) begin
                        r_valid[r_addr] <= 1'b1;
                        if (r_total != {TW{1'b1}}) begin
                            r_total <= r_total + 1'b1;
                        end
                    end
                    r_state <= S_DONE;
                end
                S_RDB: begin
                    r_res_value <= r_oor ? 64'd0 : w_cnt64;
                    r_state     <= S_DONE;
                end
                S_MUL: begin
                    r_acc  <= w_sum;
                    r_mbit <= r_mbit - 1'b1;
                    if (r_mbit == 4'd0) begin
                        r_target <= w_sum[PW-1:l2lh_pkg::Q16_BITS];
                        r_state  <= S_WREAD;
                    end
                end
                S_WREAD: begin
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    r_cum <= w_sum[TW-1:0];
                    if (w_sum > PW'(r_target) || r_addr == IW'(BUCKETS - 1)) begin
                        r_res_value <= w_bound;
                        r_state     <= S_DONE;
                    end else begin
                        r_addr  <= r_addr + 1'b1;
                        r_state <= S_WREAD;
                    end
                end
                S_DONE: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load) begin
            r_ov <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_value <= r_res_value[l2lh_pkg::VALUE_W-1:0];
            r_o_used  <= w_used8[l2lh_pkg::USED_W-1:0];
            r_o_total <= w_tot64[l2lh_pkg::TOTAL_W-1:0];
        end
    end

endmodule

`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for log2_latency_histogram
// Drives opcode requests (record, percentile query, bucket read, clear)
// through valid/ready channels with random gaps and a long sink hold-off.
// Expected responses come from a local histogram copy, checked in order.
// ----------------------------------------------------------------------------

module testbench;

    localparam int NUM_BINS    = 21;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 80;

    typedef struct {
        logic [l2lh_pkg::VALUE_W-1:0] value;
        logic [l2lh_pkg::USED_W-1:0]  used;
        logic [l2lh_pkg::TOTAL_W-1:0] total;
    } t_readout;

    logic clk = 1'b0;
    logic rst_n;

    l2lh_req_if req_ch ();
    l2lh_rsp_if rsp_ch ();

    log2_latency_histogram #(
        .BUCKETS    (NUM_BINS),
        .COUNT_WIDTH(32)
    ) i_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    // histogram copy
    logic [31:0]                  bin_count [NUM_BINS];
    logic [l2lh_pkg::TOTAL_W-1:0] sample_total;

    t_readout pending_readouts [$];
    int       mismatch_count = 0;
    int       cycle_count    = 0;
    int       req_gap_max    = 0;
    int       rsp_gap_max    = 0;
    int       hold_cycles    = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [l2lh_pkg::USED_W-1:0] bucket_of(
        input logic [l2lh_pkg::LAT_W-1:0] ns);
        int msb;
        msb = 0;
        for (int b = 0; b < l2lh_pkg::LAT_W; b++)
            if (ns[b]) msb = b;
        if (ns < (64'd1 << l2lh_pkg::SMALL_SHIFT))
            return '0;
        if (msb - l2lh_pkg::INDEX_OFFSET >= NUM_BINS - 1)
            return l2lh_pkg::USED_W'(NUM_BINS - 1);
        return l2lh_pkg::USED_W'(msb - l2lh_pkg::INDEX_OFFSET);
    endfunction

    function automatic logic [l2lh_pkg::VALUE_W-1:0] bound_of(input int idx);
        if (idx == 0)
            return l2lh_pkg::VALUE_W'(64'd1 << l2lh_pkg::SMALL_SHIFT);
        if (idx >= NUM_BINS - 1)
            return l2lh_pkg::VALUE_W'(64'd1 << l2lh_pkg::TOP_SHIFT);
        return l2lh_pkg::VALUE_W'(64'd1 << (idx + l2lh_pkg::BOUND_SHIFT_BASE));
    endfunction

    function automatic logic [l2lh_pkg::VALUE_W-1:0] rank_bound(
        input logic [l2lh_pkg::PCT_W-1:0] frac);
        logic [63:0] tot;
        logic [63:0] p;
        logic [63:0] rank;
        logic [63:0] cum;
        tot = 64'(sample_total);
        p   = 64'(frac);
        cum = '0;
        if (tot == 64'd0)
            return '0;
        if (p >= (64'd1 << l2lh_pkg::Q16_BITS)) begin
            rank = tot - 64'd1;
        end else begin
            rank = (tot >> l2lh_pkg::Q16_BITS) * p
                 + (((tot & 64'hFFFF) * p) >> l2lh_pkg::Q16_BITS);
            if (rank >= tot)
                rank = tot - 64'd1;
        end
        for (int i = 0; i < NUM_BINS; i++) begin
            cum += {32'd0, bin_count[i]};
            if (cum > rank)
                return bound_of(i);
        end
        return l2lh_pkg::VALUE_W'(64'd1 << l2lh_pkg::TOP_SHIFT);
    endfunction

    function automatic t_readout compute_readout(input l2lh_pkg::t_opcode op,
                                                 input logic [l2lh_pkg::LAT_W-1:0] lat,
                                                 input logic [l2lh_pkg::PCT_W-1:0] frac,
                                                 input logic [l2lh_pkg::SEL_W-1:0] sel);
        t_readout r;
        logic [l2lh_pkg::USED_W-1:0] b;
        r.value = '0;
        r.used  = '0;
        case (op)
            l2lh_pkg::OP_RECORD: begin
                b = bucket_of(lat);
                if (bin_count[b] != 32'hFFFF_FFFF) begin
                    bin_count[b]++;
                    sample_total++;
                end
                r.used = b;
            end
            l2lh_pkg::OP_QUERY: begin
                r.value = rank_bound(frac);
            end
            l2lh_pkg::OP_READ: begin
                if (sel < NUM_BINS)
                    r.value = bin_count[sel];
            end
            default: begin
                for (int i = 0; i < NUM_BINS; i++)
                    bin_count[i] = '0;
                sample_total = '0;
            end
        endcase
        r.total = sample_total;
        return r;
    endfunction

    task automatic send_request(input l2lh_pkg::t_opcode op,
                                input logic [l2lh_pkg::LAT_W-1:0] lat,
                                input logic [l2lh_pkg::PCT_W-1:0] frac,
                                input logic [l2lh_pkg::SEL_W-1:0] sel);
        int gap;
        gap = $urandom_range(0, req_gap_max);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.opcode     <= op;
        req_ch.latency    <= lat;
        req_ch.pct_frac   <= frac;
        req_ch.bucket_sel <= sel;
        do
            @(posedge clk);
        while (!(req_ch.valid === 1'b1 && req_ch.ready === 1'b1));
        pending_readouts.push_back(compute_readout(op, lat, frac, sel));
    endtask

    task automatic send_random_request();
        int                pick;
        l2lh_pkg::t_opcode op;
        logic [63:0]       lat;
        logic [31:0]       frac;
        logic [31:0]       sel;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            op = l2lh_pkg::OP_RECORD;
        else if (pick < 75)
            op = l2lh_pkg::OP_QUERY;
        else if (pick < 97)
            op = l2lh_pkg::OP_READ;
        else
            op = l2lh_pkg::OP_CLEAR;
        lat  = {$urandom, $urandom} >> $urandom_range(0, 63);
        frac = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 65536);
        sel  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                           : $urandom_range(0, NUM_BINS - 1);
        send_request(op, lat, frac[l2lh_pkg::PCT_W-1:0], sel[l2lh_pkg::SEL_W-1:0]);
    endtask

    task automatic test_empty_histogram();
        send_request(l2lh_pkg::OP_QUERY, '0, 17'd0, '0);
        send_request(l2lh_pkg::OP_QUERY, '1, 17'd65536, '1);
    endtask

    task automatic test_bucket_edges();
        send_request(l2lh_pkg::OP_RECORD, 64'd0, '0, '0);
        send_request(l2lh_pkg::OP_RECORD, 64'd1023, '0, '0);
        send_request(l2lh_pkg::OP_RECORD, 64'd1024, '0, '0);
        send_request(l2lh_pkg::OP_RECORD, 64'd2047, '0, '0);
        send_request(l2lh_pkg::OP_RECORD, 64'd2048, '0, '0);
        send_request(l2lh_pkg::OP_RECORD, (64'd1 << 29) - 64'd1, '0, '0);
        send_request(l2lh_pkg::OP_RECORD, 64'd1 << 29, '0, '0);
        send_request(l2lh_pkg::OP_RECORD, 64'h8000_0000_0000_0000, '0, '0);
        send_request(l2lh_pkg::OP_RECORD, '1, '1, '1);
    endtask

    task automatic test_reads_and_ranks();
        send_request(l2lh_pkg::OP_READ, '0, '0, 6'd0);
        send_request(l2lh_pkg::OP_READ, '0, '0, 6'(NUM_BINS - 1));
        send_request(l2lh_pkg::OP_READ, '0, '0, 6'(NUM_BINS));
        send_request(l2lh_pkg::OP_READ, '0, '0, 6'd63);
        send_request(l2lh_pkg::OP_QUERY, '0, 17'd0, '0);
        send_request(l2lh_pkg::OP_QUERY, '0, 17'd32768, '0);
        send_request(l2lh_pkg::OP_QUERY, '0, 17'd65535, '0);
        send_request(l2lh_pkg::OP_QUERY, '0, 17'd65536, '0);
        send_request(l2lh_pkg::OP_QUERY, '0, 17'h1FFFF, '0);
        send_request(l2lh_pkg::OP_CLEAR, '1, '1, '1);
        send_request(l2lh_pkg::OP_QUERY, '0, 17'd32768, '0);
    endtask

    task automatic test_random_mix(input int count, input int src_gap, input int dst_gap);
        req_gap_max = src_gap;
        rsp_gap_max = dst_gap;
        repeat (count) send_random_request();
    endtask

    task automatic test_backpressure();
        req_gap_max = 0;
        rsp_gap_max = 0;
        hold_cycles = 300;
        repeat (40) send_random_request();
    endtask

    // response sink: per-response stall, plus long hold-off on request
    initial begin : sink_side
        int stall;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (hold_cycles > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            stall = $urandom_range(0, rsp_gap_max);
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) && hold_cycles == 0);
        end
    end

    always @(posedge clk) begin : response_check
        t_readout exp_r;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (pending_readouts.size() == 0) begin
                $display("%0t: response with no request outstanding", $time);
                mismatch_count++;
            end else begin
                exp_r = pending_readouts.pop_front();
                if (rsp_ch.value !== exp_r.value) begin
                    $display("%0t: value expected %0h actual %0h",
                             $time, exp_r.value, rsp_ch.value);
                    mismatch_count++;
                end
                if (rsp_ch.bucket_used !== exp_r.used) begin
                    $display("%0t: bucket_used expected %0d actual %0d",
                             $time, exp_r.used, rsp_ch.bucket_used);
                    mismatch_count++;
                end
                if (rsp_ch.total_count !== exp_r.total) begin
                    $display("%0t: total_count expected %0h actual %0h",
                             $time, exp_r.total, rsp_ch.total_count);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.opcode     = l2lh_pkg::OP_RECORD;
        req_ch.latency    = '0;
        req_ch.pct_frac   = '0;
        req_ch.bucket_sel = '0;
        for (int i = 0; i < NUM_BINS; i++)
            bin_count[i] = '0;
        sample_total = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_histogram();
        test_bucket_edges();
        test_reads_and_ranks();
        test_random_mix(450, 15, 15);
        test_random_mix(400, 0, 0);
        test_backpressure();
        test_random_mix(400, 0, 15);
        test_random_mix(410, 15, 0);
        req_ch.valid <= 1'b0;

        while (pending_readouts.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0 && pending_readouts.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: sim.f
sv/l2lh_pkg.sv
sv/l2lh_req_if.sv
sv/l2lh_rsp_if.sv
sv/log2_latency_histogram.sv
verif/testbench.sv
